// File: design/lfs_pkg.sv
`timescale 1ns / 1ps

package lfs_pkg;

  localparam int unsigned CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Item kinds carried in the command field.
  localparam logic CMD_TICK         = 1'b0;
  localparam logic CMD_PRIMARY_DATA = 1'b1;

  typedef enum logic [1:0] {
    LINK_NONE    = 2'd0,
    LINK_PRIMARY = 2'd1,
    LINK_BACKUP  = 2'd2
  } link_e;

  typedef enum logic [2:0] {
    REASON_UNCHANGED    = 3'd0,
    REASON_CONGESTED    = 3'd1,
    REASON_RECOVERED    = 3'd2,
    REASON_NO_LINK      = 3'd3,
    REASON_PRIMARY_CONN = 3'd4,
    REASON_BACKUP_ONLY  = 3'd5,
    REASON_PRIMARY_DATA = 3'd6
  } reason_e;

  typedef enum logic [2:0] {
    CFG_COOLDOWN_MS     = 3'd0,
    CFG_MAX_LATENCY_MS  = 3'd1,
    CFG_MIN_PACKET_RATE = 3'd2,
    CFG_MAX_ERRORS      = 3'd3,
    CFG_CONGEST_LIMIT   = 3'd4,
    CFG_RECOVERY_LAT_MS = 3'd5,
    CFG_RECOVERY_LIMIT  = 3'd6
  } cfg_idx_e;

  localparam logic [15:0] RST_COOLDOWN_MS     = 16'd2000;
  localparam logic [15:0] RST_MAX_LATENCY_MS  = 16'd100;
  localparam logic [15:0] RST_MIN_PACKET_RATE = 16'd10;
  localparam logic [15:0] RST_MAX_ERRORS      = 16'd10;
  localparam logic [15:0] RST_CONGEST_LIMIT   = 16'd3;
  localparam logic [15:0] RST_RECOVERY_LAT_MS = 16'd50;
  localparam logic [15:0] RST_RECOVERY_LIMIT  = 16'd10;

  typedef struct packed {
    logic [15:0] cooldown_ms;
    logic [15:0] max_latency_ms;
    logic [15:0] min_packet_rate;
    logic [15:0] max_errors;
    logic [15:0] congestion_limit;
    logic [15:0] recovery_latency_ms;
    logic [15:0] recovery_limit;
  } lfs_cfg_t;

  typedef struct packed {
    logic        command;
    logic [31:0] now_ms;
    logic [15:0] primary_latency_ms;
    logic [15:0] primary_rate;
    logic [15:0] primary_error_count;
    logic        primary_ever_counted;
    logic        backup_present;
    logic [15:0] backup_rate;
  } lfs_in_t;

  typedef struct packed {
    logic [1:0]  active_link;
    logic        switched;
    logic [2:0]  reason_code;
    logic        cooling_down;
    logic        primary_congested_flag;
    logic [15:0] congestion_run;
    logic [15:0] recovery_run;
  } lfs_out_t;

  // Selector state apart from the timestamps, whose width is a parameter.
  typedef struct packed {
    link_e            link;
    logic [CNT_W-1:0] congest;
    logic [CNT_W-1:0] recover;
    logic             mark;
    logic             has_sw;
    logic             seen;
  } lfs_state_t;

endpackage

// File: design/link_failover_selector.sv
`timescale 1ns / 1ps
// Flow: an accepted request is held in the request register and moves into
// the result register, where it is offered, once that register is free.
// Throughput: one request per cycle, sustained, as long as results are taken.
// Reset (rst_ni, asynchronous, active low) clears the link state, counters,
// flags and timestamps and loads the configuration registers' defaults.

module link_failover_selector #(
  parameter int unsigned ALIVE_WINDOW_MS = 500,
  parameter int unsigned TIME_WIDTH      = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Request channel.
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lfs_pkg::lfs_in_t  in_data_i,
  // Result channel.
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lfs_pkg::lfs_out_t out_data_o,
  // Configuration write channel.
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);

  // The design has two register stages. The request register captures an
  // accepted request; the combinational decision logic then reads it along
  // with the selector state; when the result register can advance, the state
  // and the result register are updated together. As the state is written
  // by the edge that consumes the request, the following request already sees
  // it, so requests can follow every cycle while results are taken.

  lfs_pkg::lfs_cfg_t   cfg;
  lfs_pkg::lfs_in_t    req_q;
  logic                req_vld_q;
  lfs_pkg::lfs_out_t   res_q;
  lfs_pkg::lfs_out_t   res_d;
  logic                res_vld_q;
  lfs_pkg::lfs_state_t state_q;
  lfs_pkg::lfs_state_t state_d;
  logic [TIME_WIDTH-1:0] last_sw_q;
  logic [TIME_WIDTH-1:0] last_sw_d;
  logic [TIME_WIDTH-1:0] last_pri_q;
  logic [TIME_WIDTH-1:0] last_pri_d;
  logic                advance;
  logic                fire;
  logic                take;

  // Configuration writes are always accepted.
  assign cfg_ready_o = 1'b1;

  lfs_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_valid_i),
    .idx_i  (cfg_index_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  lfs_core #(
    .ALIVE_WINDOW_MS (ALIVE_WINDOW_MS),
    .TIME_WIDTH      (TIME_WIDTH)
  ) u_core (
    .item_i     (req_q),
    .cfg_i      (cfg),
    .state_i    (state_q),
    .last_sw_i  (last_sw_q),
    .last_pri_i (last_pri_q),
    .state_o    (state_d),
    .last_sw_o  (last_sw_d),
    .last_pri_o (last_pri_d),
    .result_o   (res_d)
  );

  // The result register can take a new value when it is empty or being
  // drained this cycle. The request register then moves into it, and may
  // itself be refilled in the same cycle.
  assign advance    = !res_vld_q || out_ready_i;
  assign fire       = req_vld_q && advance;
  assign in_ready_o = !req_vld_q || advance;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q        <= 1'b0;
      res_vld_q        <= 1'b0;
      state_q.link     <= lfs_pkg::LINK_NONE;
      state_q.congest  <= '0;
      state_q.recover  <= '0;
      state_q.mark     <= 1'b0;
      state_q.has_sw   <= 1'b0;
      state_q.seen     <= 1'b0;
      last_sw_q        <= '0;
      last_pri_q       <= '0;
    end else begin
      if (take) begin
        req_vld_q <= 1'b1;
      end else if (advance) begin
        req_vld_q <= 1'b0;
      end
      if (fire) begin
        res_vld_q  <= 1'b1;
        state_q    <= state_d;
        last_sw_q  <= last_sw_d;
        last_pri_q <= last_pri_d;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset; their valid bits qualify them.
  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q <= in_data_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

endmodule

// File: design/lfs_cfg_regs.sv
`timescale 1ns / 1ps

module lfs_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [2:0]        idx_i,
  input  logic [15:0]       data_i,
  output lfs_pkg::lfs_cfg_t cfg_o
);

  lfs_pkg::lfs_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (lfs_pkg::cfg_idx_e'(idx_i))
        lfs_pkg::CFG_COOLDOWN_MS:     cfg_d.cooldown_ms         = data_i;
        lfs_pkg::CFG_MAX_LATENCY_MS:  cfg_d.max_latency_ms      = data_i;
        lfs_pkg::CFG_MIN_PACKET_RATE: cfg_d.min_packet_rate     = data_i;
        lfs_pkg::CFG_MAX_ERRORS:      cfg_d.max_errors          = data_i;
        lfs_pkg::CFG_CONGEST_LIMIT:   cfg_d.congestion_limit    = data_i;
        lfs_pkg::CFG_RECOVERY_LAT_MS: cfg_d.recovery_latency_ms = data_i;
        lfs_pkg::CFG_RECOVERY_LIMIT:  cfg_d.recovery_limit      = data_i;
        default: ;  // Writes past the register list are dropped.
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cooldown_ms         <= lfs_pkg::RST_COOLDOWN_MS;
      cfg_q.max_latency_ms      <= lfs_pkg::RST_MAX_LATENCY_MS;
      cfg_q.min_packet_rate     <= lfs_pkg::RST_MIN_PACKET_RATE;
      cfg_q.max_errors          <= lfs_pkg::RST_MAX_ERRORS;
      cfg_q.congestion_limit    <= lfs_pkg::RST_CONGEST_LIMIT;
      cfg_q.recovery_latency_ms <= lfs_pkg::RST_RECOVERY_LAT_MS;
      cfg_q.recovery_limit      <= lfs_pkg::RST_RECOVERY_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/lfs_core.sv
`timescale 1ns / 1ps

module lfs_core #(
  parameter int unsigned ALIVE_WINDOW_MS = 500,
  parameter int unsigned TIME_WIDTH      = 32
) (
  input  lfs_pkg::lfs_in_t        item_i,
  input  lfs_pkg::lfs_cfg_t       cfg_i,
  input  lfs_pkg::lfs_state_t     state_i,
  input  logic [TIME_WIDTH-1:0]   last_sw_i,
  input  logic [TIME_WIDTH-1:0]   last_pri_i,
  output lfs_pkg::lfs_state_t     state_o,
  output logic [TIME_WIDTH-1:0]   last_sw_o,
  output logic [TIME_WIDTH-1:0]   last_pri_o,
  output lfs_pkg::lfs_out_t       result_o
);

  localparam int unsigned EXT_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  logic [EXT_W-1:0]          now_ext;
  logic [TIME_WIDTH-1:0]     now_t;
  logic [TIME_WIDTH-1:0]     cooldown_t;
  logic                      cool_pre;
  logic                      cool_post;
  logic                      p_ok;
  logic                      b_ok;
  logic                      congested;
  logic                      recovered;
  logic [lfs_pkg::CNT_W-1:0] cong_inc;
  logic [lfs_pkg::CNT_W-1:0] rec_inc;
  logic                      switched;
  lfs_pkg::reason_e          reason;

  assign now_ext    = EXT_W'(item_i.now_ms);
  assign now_t      = now_ext[TIME_WIDTH-1:0];
  assign cooldown_t = TIME_WIDTH'(cfg_i.cooldown_ms);

  // Elapsed times are taken modulo the timestamp width by plain subtraction.
  assign cool_pre = state_i.has_sw && ((now_t - last_sw_i) < cooldown_t);
  assign p_ok     = state_i.seen &&
                    ((now_t - last_pri_i) < TIME_WIDTH'(ALIVE_WINDOW_MS));
  assign b_ok     = item_i.backup_present && (item_i.backup_rate != '0);

  assign congested = p_ok &&
                     ((item_i.primary_latency_ms > cfg_i.max_latency_ms) ||
                      ((item_i.primary_rate < cfg_i.min_packet_rate) &&
                       item_i.primary_ever_counted) ||
                      (item_i.primary_error_count > cfg_i.max_errors));
  assign recovered = p_ok &&
                     (item_i.primary_latency_ms < cfg_i.recovery_latency_ms) &&
                     (item_i.primary_rate >= cfg_i.min_packet_rate);

  assign cong_inc = (state_i.congest == lfs_pkg::CNT_MAX) ? state_i.congest
                                                          : state_i.congest + 1'b1;
  assign rec_inc  = (state_i.recover == lfs_pkg::CNT_MAX) ? state_i.recover
                                                          : state_i.recover + 1'b1;

  always_comb begin
    state_o    = state_i;
    last_sw_o  = last_sw_i;
    last_pri_o = last_pri_i;
    switched   = 1'b0;
    reason     = lfs_pkg::REASON_UNCHANGED;
    if (item_i.command == lfs_pkg::CMD_PRIMARY_DATA) begin
      last_pri_o   = now_t;
      state_o.seen = 1'b1;
      if (!cool_pre && (state_i.link != lfs_pkg::LINK_PRIMARY)) begin
        state_o.link = lfs_pkg::LINK_PRIMARY;
        reason       = lfs_pkg::REASON_PRIMARY_DATA;
      end
    end else if (!(cool_pre && (state_i.link != lfs_pkg::LINK_NONE))) begin
      unique case (state_i.link)
        lfs_pkg::LINK_PRIMARY: begin
          if (congested) begin
            state_o.congest = cong_inc;
            state_o.recover = '0;
            if ((cong_inc >= cfg_i.congestion_limit) && b_ok) begin
              state_o.link    = lfs_pkg::LINK_BACKUP;
              last_sw_o       = now_t;
              state_o.has_sw  = 1'b1;
              state_o.mark    = 1'b1;
              state_o.congest = '0;
              switched        = 1'b1;
              reason          = lfs_pkg::REASON_CONGESTED;
            end
          end else begin
            state_o.congest = '0;
          end
        end
        lfs_pkg::LINK_BACKUP: begin
          if (recovered) begin
            state_o.recover = rec_inc;
            state_o.congest = '0;
            if (rec_inc >= cfg_i.recovery_limit) begin
              state_o.link    = lfs_pkg::LINK_PRIMARY;
              last_sw_o       = now_t;
              state_o.has_sw  = 1'b1;
              state_o.mark    = 1'b0;
              state_o.recover = '0;
              switched        = 1'b1;
              reason          = lfs_pkg::REASON_RECOVERED;
            end
          end else if (!p_ok && !b_ok) begin
            state_o.link = lfs_pkg::LINK_NONE;
            reason       = lfs_pkg::REASON_NO_LINK;
          end else begin
            state_o.recover = '0;
          end
        end
        default: begin
          if (p_ok) begin
            state_o.link = lfs_pkg::LINK_PRIMARY;
            reason       = lfs_pkg::REASON_PRIMARY_CONN;
          end else if (b_ok) begin
            state_o.link = lfs_pkg::LINK_BACKUP;
            reason       = lfs_pkg::REASON_BACKUP_ONLY;
          end
        end
      endcase
    end
  end

  // The reported cooldown reflects the state after this item.
  assign cool_post = state_o.has_sw && ((now_t - last_sw_o) < cooldown_t);

  always_comb begin
    result_o.active_link            = state_o.link;
    result_o.switched               = switched;
    result_o.reason_code            = reason;
    result_o.cooling_down           = cool_post;
    result_o.primary_congested_flag = state_o.mark;
    result_o.congestion_run         = state_o.congest;
    result_o.recovery_run           = state_o.recover;
  end

endmodule

// File: design/lfs_checker.sv
`timescale 1ns / 1ps

module lfs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input lfs_pkg::lfs_out_t out_data_o
);

  // A stalled result holds its value until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Only congestion and recovery count as switches.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.switched |->
      (out_data_o.reason_code == lfs_pkg::REASON_CONGESTED) ||
      (out_data_o.reason_code == lfs_pkg::REASON_RECOVERED))
    else $error("switch flagged with a non-switch reason");

  // A fallback lands on the backup, sets the sticky flag and clears the run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.reason_code == lfs_pkg::REASON_CONGESTED) |->
      (out_data_o.active_link == lfs_pkg::LINK_BACKUP) &&
      out_data_o.primary_congested_flag && out_data_o.switched &&
      (out_data_o.congestion_run == '0))
    else $error("inconsistent fallback result");

  // A return lands on the primary, clears the sticky flag and the run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.reason_code == lfs_pkg::REASON_RECOVERED) |->
      (out_data_o.active_link == lfs_pkg::LINK_PRIMARY) &&
      !out_data_o.primary_congested_flag && out_data_o.switched &&
      (out_data_o.recovery_run == '0))
    else $error("inconsistent recovery result");

endmodule

bind link_failover_selector lfs_checker u_lfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
